/* design/bzq_pkg.sv */
// bzq_pkg: shared types, constants and helpers for the quintic Bezier evaluator.
// No dependencies; used by bzq_pow_cell and quintic_bezier_segment_eval_core.
package bzq_pkg;

    // Q16.16 one, Q1.16 time width
    localparam int unsigned TW    = 17;
    localparam logic [TW-1:0] QONE = 17'd65536;
    // width of control points and their differences
    localparam int unsigned DW    = 56;
    // basis value width: binomial (<= 10) times a Q1.16 product
    localparam int unsigned BW    = 21;
    // width of the final scaled value before saturation
    localparam int unsigned SW    = 81;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_VEL_FACTOR = 2'd0,
        REG_ACC_FACTOR = 2'd1,
        REG_INV_DUR    = 2'd2,
        REG_INV_DUR_SQ = 2'd3
    } t_reg_idx;

    // power row: slot 0 holds the newest power
    typedef logic [5:0][TW-1:0] t_pow_vec;

    // control points and their first and second differences
    typedef struct packed {
        logic [5:0][DW-1:0] cp;
        logic [4:0][DW-1:0] d1;
        logic [3:0][DW-1:0] d2;
    } t_ctl_pts;

    localparam logic [3:0] BIN5 [6] = '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1};
    localparam logic [3:0] BIN4 [5] = '{4'd1, 4'd4, 4'd6, 4'd4, 4'd1};
    localparam logic [3:0] BIN3 [4] = '{4'd1, 4'd3, 4'd3, 4'd1};

    // saturate to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        mx = SW'(signed'(33'sh0_7FFF_FFFF));
        mn = SW'(signed'(33'sh1_8000_0000));
        if (x > mx) begin
            return 32'h7FFF_FFFF;
        end else if (x < mn) begin
            return 32'h8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

/* design/bzq_pow_cell.sv */
// bzq_pow_cell: one cell of the power chain; forms the next power of t and of 1-t.
// Depends on bzq_pkg.
module bzq_pow_cell
    import bzq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [TW-1:0] i_t,
    input  logic [TW-1:0] i_u,
    input  t_pow_vec      i_tp,
    input  t_pow_vec      i_up,
    output logic [TW-1:0] o_t,
    output logic [TW-1:0] o_u,
    output t_pow_vec      o_tp,
    output t_pow_vec      o_up
);

    logic [2*TW-1:0] w_tprod;
    logic [2*TW-1:0] w_uprod;
    t_pow_vec        n_tp;
    t_pow_vec        n_up;

    // next power, floor of Q1.16 product; older powers shift up one slot
    always_comb begin
        w_tprod = i_tp[0] * i_t;
        w_uprod = i_up[0] * i_u;
        n_tp    = {i_tp[4:0], w_tprod[TW+15:16]};
        n_up    = {i_up[4:0], w_uprod[TW+15:16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_t  <= i_t;
            o_u  <= i_u;
            o_tp <= n_tp;
            o_up <= n_up;
        end
    end

endmodule

/* design/quintic_bezier_segment_eval_core.sv */
// quintic_bezier_segment_eval_core: top level of the quintic Bezier segment evaluator.
// Depends on bzq_pkg and bzq_pow_cell.
//
//  channel   | dir | handshake                      | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | start/end pos, vel, acc, local_time
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | position, velocity, acceleration
//  cfg       | in  | i_cfg_we                       | i_cfg_addr, i_cfg_data
//
// One item per clock while the output is not stalled; each item passes through the stage chain
// (one front stage, five power cells, basis, terms, sums, two scaling stages).
// Reset clears all stage valids and loads every scale register with 1.0.
// A stalled output freezes the whole chain; s_axis_tready follows that stall.
module quintic_bezier_segment_eval_core
    import bzq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, local_time, zero pad
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position, velocity, acceleration
    output logic [95:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);

    localparam int unsigned NST = 11;

    logic [31:0]    r_vf, r_af, r_id, r_id2;
    logic [NST-1:0] r_vld;
    logic           w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf  <= 32'd65536;
            r_af  <= 32'd65536;
            r_id  <= 32'd65536;
            r_id2 <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_VEL_FACTOR: r_vf  <= i_cfg_data;
                REG_ACC_FACTOR: r_af  <= i_cfg_data;
                REG_INV_DUR:    r_id  <= i_cfg_data;
                REG_INV_DUR_SQ: r_id2 <= i_cfg_data;
                default:        r_vf  <= r_vf;
            endcase
        end
    end

    // chain advances unless the output item is held
    assign w_en          = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage 1: clamp time, scale velocities and accelerations
    logic signed [31:0] w_p0, w_v0, w_a0, w_p1, w_v1, w_a1;
    logic [TW-1:0]      w_t;
    logic signed [64:0] w_svp, w_evp, w_sap, w_eap;
    logic [TW-1:0]      r1_t, r1_u;
    logic signed [DW-1:0] r1_p0, r1_p1, r1_sv, r1_ev, r1_sa, r1_ea;

    always_comb begin
        w_p0  = s_axis_tdata[31:0];
        w_v0  = s_axis_tdata[63:32];
        w_a0  = s_axis_tdata[95:64];
        w_p1  = s_axis_tdata[127:96];
        w_v1  = s_axis_tdata[159:128];
        w_a1  = s_axis_tdata[191:160];
        w_t   = (s_axis_tdata[208:192] > QONE) ? QONE : s_axis_tdata[208:192];
        w_svp = w_v0 * $signed({1'b0, r_vf});
        w_evp = w_v1 * $signed({1'b0, r_vf});
        w_sap = w_a0 * $signed({1'b0, r_af});
        w_eap = w_a1 * $signed({1'b0, r_af});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_t  <= w_t;
            r1_u  <= QONE - w_t;
            r1_p0 <= DW'(w_p0);
            r1_p1 <= DW'(w_p1);
            r1_sv <= DW'($signed(w_svp[64:16]));
            r1_ev <= DW'($signed(w_evp[64:16]));
            r1_sa <= DW'($signed(w_sap[64:16]));
            r1_ea <= DW'($signed(w_eap[64:16]));
        end
    end

    // power chain: five cells, powers zero to five of t and 1-t
    logic [TW-1:0] w_ct [6];
    logic [TW-1:0] w_cu [6];
    t_pow_vec      w_ctp [6];
    t_pow_vec      w_cup [6];

    assign w_ct[0]  = r1_t;
    assign w_cu[0]  = r1_u;
    assign w_ctp[0] = {{5{TW'(0)}}, QONE};
    assign w_cup[0] = {{5{TW'(0)}}, QONE};

    for (genvar g = 0; g < 5; g++) begin : g_cell
        bzq_pow_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_t   (w_ct[g]),
            .i_u   (w_cu[g]),
            .i_tp  (w_ctp[g]),
            .i_up  (w_cup[g]),
            .o_t   (w_ct[g+1]),
            .o_u   (w_cu[g+1]),
            .o_tp  (w_ctp[g+1]),
            .o_up  (w_cup[g+1])
        );
    end

    // stage 2: control points
    logic signed [DW-1:0] r2_cp [6];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cp[0] <= r1_p0;
            r2_cp[1] <= r1_p0 + r1_sv;
            r2_cp[2] <= r1_p0 + (r1_sv <<< 1) + r1_sa;
            r2_cp[3] <= r1_p1 - (r1_ev <<< 1) + r1_ea;
            r2_cp[4] <= r1_p1 - r1_ev;
            r2_cp[5] <= r1_p1;
        end
    end

    // stage 3: differences, then carried along to stage 7
    t_ctl_pts n_pts;
    t_ctl_pts r_pts [4];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_pts.cp[k] = r2_cp[k];
        end
        for (int k = 0; k < 5; k++) begin
            n_pts.d1[k] = r2_cp[k+1] - r2_cp[k];
        end
        for (int k = 0; k < 4; k++) begin
            n_pts.d2[k] = r2_cp[k+2] - (r2_cp[k+1] <<< 1) + r2_cp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts[0] <= n_pts;
            for (int i = 1; i < 4; i++) begin
                r_pts[i] <= r_pts[i-1];
            end
        end
    end

    // stage 7: Bernstein basis values; cell row holds t^(5-i) in slot i
    logic [BW-1:0]   r_b5 [6];
    logic [BW-1:0]   r_b4 [5];
    logic [BW-1:0]   r_b3 [4];
    logic [BW-1:0]   n_b5 [6];
    logic [BW-1:0]   n_b4 [5];
    logic [BW-1:0]   n_b3 [4];
    logic [2*TW-1:0] w_bp5 [6];
    logic [2*TW-1:0] w_bp4 [5];
    logic [2*TW-1:0] w_bp3 [4];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_bp5[k] = w_ctp[5][5-k] * w_cup[5][k];
            n_b5[k]  = BW'(w_bp5[k][TW+15:16] * BIN5[k]);
        end
        for (int k = 0; k < 5; k++) begin
            w_bp4[k] = w_ctp[5][5-k] * w_cup[5][k+1];
            n_b4[k]  = BW'(w_bp4[k][TW+15:16] * BIN4[k]);
        end
        for (int k = 0; k < 4; k++) begin
            w_bp3[k] = w_ctp[5][5-k] * w_cup[5][k+2];
            n_b3[k]  = BW'(w_bp3[k][TW+15:16] * BIN3[k]);
        end
    end

    t_ctl_pts r7_pts;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b5   <= n_b5;
            r_b4   <= n_b4;
            r_b3   <= n_b3;
            r7_pts <= r_pts[3];
        end
    end

    // stage 8: weighted terms, floor of Q16.16 products
    logic signed [DW+BW:0] w_m5 [6];
    logic signed [DW+BW:0] w_m4 [5];
    logic signed [DW+BW:0] w_m3 [4];
    logic signed [63:0]    r_tm5 [6];
    logic signed [63:0]    r_tm4 [5];
    logic signed [63:0]    r_tm3 [4];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_m5[k] = $signed(r7_pts.cp[k]) * $signed({1'b0, r_b5[k]});
        end
        for (int k = 0; k < 5; k++) begin
            w_m4[k] = $signed(r7_pts.d1[k]) * $signed({1'b0, r_b4[k]});
        end
        for (int k = 0; k < 4; k++) begin
            w_m3[k] = $signed(r7_pts.d2[k]) * $signed({1'b0, r_b3[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) r_tm5[k] <= 64'($signed(w_m5[k][DW+BW:16]));
            for (int k = 0; k < 5; k++) r_tm4[k] <= 64'($signed(w_m4[k][DW+BW:16]));
            for (int k = 0; k < 4; k++) r_tm3[k] <= 64'($signed(w_m3[k][DW+BW:16]));
        end
    end

    // stage 9: sums, derivative factors five and twenty
    logic signed [63:0] r9_pos, r9_vel, r9_acc;
    logic signed [63:0] w_vs, w_as;

    always_comb begin
        w_vs = r_tm4[0] + r_tm4[1] + r_tm4[2] + r_tm4[3] + r_tm4[4];
        w_as = r_tm3[0] + r_tm3[1] + r_tm3[2] + r_tm3[3];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_pos <= r_tm5[0] + r_tm5[1] + r_tm5[2] + r_tm5[3] + r_tm5[4] + r_tm5[5];
            r9_vel <= (w_vs <<< 2) + w_vs;
            r9_acc <= (w_as <<< 4) + (w_as <<< 2);
        end
    end

    // stage 10: duration scaling as two 16-bit partial products each
    logic signed [SW-1:0] r10_vh, r10_vl, r10_ah, r10_al;
    logic signed [63:0]   r10_pos;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_vh  <= r9_vel * $signed({1'b0, r_id[31:16]});
            r10_vl  <= r9_vel * $signed({1'b0, r_id[15:0]});
            r10_ah  <= r9_acc * $signed({1'b0, r_id2[31:16]});
            r10_al  <= r9_acc * $signed({1'b0, r_id2[15:0]});
            r10_pos <= r9_pos;
        end
    end

    // stage 11: combine partials, saturate, output register
    logic signed [SW+15:0] w_vsum, w_asum;

    always_comb begin
        w_vsum = ((SW+16)'(r10_vh) <<< 16) + (SW+16)'(r10_vl);
        w_asum = ((SW+16)'(r10_ah) <<< 16) + (SW+16)'(r10_al);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {sat32(w_asum[SW+15:16]),
                             sat32(w_vsum[SW+15:16]),
                             sat32(SW'(r10_pos))};
        end
    end

    // clamped time never exceeds one
    a_time_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r1_t <= QONE && (r1_t + r1_u) == (TW+1)'(QONE)))
        else $error("time clamp broken");

    // a held output freezes every stage valid
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("chain moved during stall");

    // quintic basis never sums above one
    a_basis_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> ((24'(r_b5[0]) + 24'(r_b5[1]) + 24'(r_b5[2]) + 24'(r_b5[3])
                       + 24'(r_b5[4]) + 24'(r_b5[5])) <= 24'(QONE)))
        else $error("basis sum above one");

endmodule
